// ----- rtl/ole_pkg.sv -----
// shared types and constants for the ordered list engine
package ole_pkg;

   localparam int COMMAND_W  = 3;
   localparam int VALUE_W    = 32;
   localparam int INDEX_W    = 7;
   localparam int STATUS_W   = 2;
   localparam int POSITION_W = 6;
   localparam int COUNT_W    = 7;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_BACK  = 3'd1,
      CMD_INS_AT    = 3'd2,
      CMD_REM_FRONT = 3'd3,
      CMD_REM_BACK  = 3'd4,
      CMD_REM_AT    = 3'd5,
      CMD_READ_AT   = 3'd6,
      CMD_FIND      = 3'd7
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_RANGE     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

   typedef struct packed {
      command_type               command;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        index;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [VALUE_W-1:0] data;
      logic [POSITION_W-1:0]     position;
      logic [COUNT_W-1:0]        count;
   } rsp_type;

endpackage

// ----- rtl/ole_cell.sv -----
// one list slot: holds an entry, shifts with its neighbors, compares and selects
module ole_cell #(
   parameter int POS = 0,
   parameter int CW  = 7
) (
   input  logic                               clock,
   input  ole_pkg::cell_ctrl_type             ctrl,
   input  logic [CW-1:0]                      at_pos,
   input  logic [CW-1:0]                      fill,
   input  logic signed [ole_pkg::VALUE_W-1:0] prev_entry,
   input  logic signed [ole_pkg::VALUE_W-1:0] next_entry,
   output logic signed [ole_pkg::VALUE_W-1:0] entry,
   output logic                               hit,
   output logic signed [ole_pkg::VALUE_W-1:0] sel_data
);
   import ole_pkg::*;

   localparam logic [CW-1:0] POS_V    = CW'(POS);
   localparam logic [CW-1:0] POS_NEXT = CW'(POS + 1);

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         CELL_INSERT: begin
            priority if (POS_V == at_pos) begin
               entry_in = ctrl.value;
            end else if (POS_V > at_pos && POS_V <= fill) begin
               entry_in = prev_entry;
            end else begin
               entry_in = entry_ff;
            end
         end
         CELL_REMOVE: begin
            // slots from the gap up to the new tail pull from the right
            if (POS_V >= at_pos && POS_NEXT < fill) begin
               entry_in = next_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry    = entry_ff;
   assign hit      = (entry_ff == ctrl.value) && (POS_V < fill);
   assign sel_data = (POS_V == at_pos) ? entry_ff : '0;

endmodule

// ----- rtl/ordered_list_engine.sv -----
// ordered list engine top: command decode, row of list cells, result stages
// a request is taken when start is high and busy low; busy is high for the one
// evaluation cycle after, and no new request is taken during that cycle
// the result strobe rsp_valid is registered after stage 2 and lasts one cycle;
// the first-match position is encoded from registered compare bits
// synchronous reset empties the list and clears all valid flags
module ordered_list_engine #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ole_pkg::req_type req_payload,
   output logic             rsp_valid,
   output ole_pkg::rsp_type rsp_payload
);
   import ole_pkg::*;

   localparam int FW = $clog2(CAPACITY + 1);
   localparam int CW = (FW > INDEX_W) ? FW : INDEX_W;
   localparam int PW = $clog2(CAPACITY);
   localparam logic [FW-1:0] CAP_V = FW'(CAPACITY);

   // stage 1: latched request
   logic    eval_ff;
   req_type req_ff;

   // list length
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] fill_in;

   // cell row
   cell_ctrl_type             cell_ctrl;
   logic [CW-1:0]             at_cw;
   logic [CW-1:0]             fill_cw;
   logic [CW-1:0]             idx_cw;
   logic signed [VALUE_W-1:0] entries  [CAPACITY];
   logic signed [VALUE_W-1:0] sel_data [CAPACITY];
   logic [CAPACITY-1:0]       hits;
   logic signed [VALUE_W-1:0] sel_or;

   // stage 1 decode results
   cell_op_type               op_dec;
   status_type                status_dec;
   logic signed [VALUE_W-1:0] data_dec;
   logic                      find_dec;

   // stage 2
   logic                      s2_valid_ff;
   logic                      s2_find_ff;
   status_type                s2_status_ff;
   logic signed [VALUE_W-1:0] s2_data_ff;
   logic [FW-1:0]             s2_fill_ff;
   logic [CAPACITY-1:0]       s2_hit_ff;
   logic [PW-1:0]             first_pos;
   rsp_type                   rsp_in;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   assign busy    = eval_ff;
   assign fill_cw = CW'(fill_ff);
   assign idx_cw  = CW'(req_ff.index);

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_ff <= 1'b0;
      end else begin
         eval_ff <= start && !eval_ff;
      end
      if (start && !eval_ff) begin
         req_ff <= req_payload;
      end
   end

   always_comb begin
      sel_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_or = sel_or | sel_data[i];
      end
   end

   always_comb begin
      at_cw      = '0;
      op_dec     = CELL_HOLD;
      status_dec = ST_OK;
      data_dec   = '0;
      find_dec   = 1'b0;
      fill_in    = fill_ff;
      unique case (req_ff.command)
         CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
            priority if (req_ff.command == CMD_INS_FRONT) begin
               at_cw = '0;
            end else if (req_ff.command == CMD_INS_BACK) begin
               at_cw = fill_cw;
            end else begin
               at_cw = idx_cw;
            end
            priority if (at_cw > fill_cw) begin
               status_dec = ST_RANGE;
            end else if (fill_ff >= CAP_V) begin
               status_dec = ST_FULL;
            end else begin
               op_dec  = CELL_INSERT;
               fill_in = fill_ff + FW'(1);
            end
         end
         CMD_REM_FRONT, CMD_REM_BACK, CMD_REM_AT: begin
            priority if (req_ff.command == CMD_REM_FRONT) begin
               at_cw = '0;
            end else if (req_ff.command == CMD_REM_BACK) begin
               at_cw = fill_cw - CW'(1);
            end else begin
               at_cw = idx_cw;
            end
            if (fill_ff == '0 || at_cw >= fill_cw) begin
               status_dec = ST_RANGE;
            end else begin
               op_dec   = CELL_REMOVE;
               data_dec = sel_or;
               fill_in  = fill_ff - FW'(1);
            end
         end
         CMD_READ_AT: begin
            at_cw = idx_cw;
            if (at_cw >= fill_cw) begin
               status_dec = ST_RANGE;
            end else begin
               data_dec = sel_or;
            end
         end
         default: begin
            find_dec = 1'b1;
         end
      endcase
   end

   assign cell_ctrl.op    = eval_ff ? op_dec : CELL_HOLD;
   assign cell_ctrl.value = req_ff.value;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_w;
      logic signed [VALUE_W-1:0] next_w;
      if (g == 0) begin : g_first
         assign prev_w = '0;
      end else begin : g_mid_prev
         assign prev_w = entries[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign next_w = '0;
      end else begin : g_mid_next
         assign next_w = entries[g+1];
      end
      ole_cell #(
         .POS (g),
         .CW  (CW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .at_pos     (at_cw),
         .fill       (fill_cw),
         .prev_entry (prev_w),
         .next_entry (next_w),
         .entry      (entries[g]),
         .hit        (hits[g]),
         .sel_data   (sel_data[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= eval_ff;
         if (eval_ff) begin
            fill_ff <= fill_in;
         end
      end
      if (eval_ff) begin
         s2_find_ff   <= find_dec;
         s2_status_ff <= status_dec;
         s2_data_ff   <= data_dec;
         s2_fill_ff   <= fill_in;
         s2_hit_ff    <= hits;
      end
   end

   // lowest set compare bit wins
   always_comb begin
      first_pos = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (s2_hit_ff[i]) begin
            first_pos = PW'(i);
         end
      end
   end

   always_comb begin
      rsp_in.status   = s2_status_ff;
      rsp_in.data     = s2_data_ff;
      rsp_in.position = '0;
      rsp_in.count    = COUNT_W'(s2_fill_ff);
      if (s2_find_ff) begin
         if (|s2_hit_ff) begin
            rsp_in.status   = ST_OK;
            rsp_in.position = POSITION_W'(first_pos);
         end else begin
            rsp_in.status = ST_NOT_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (s2_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##3 rsp_valid)
      else $error("request did not produce a result after three cycles");

   a_single_eval : assert property (@(posedge clock) disable iff (reset)
      eval_ff |=> !eval_ff)
      else $error("evaluation lasted more than one cycle");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CAP_V)
      else $error("list length beyond capacity");

   a_fill_hold : assert property (@(posedge clock) disable iff (reset)
      eval_ff && status_dec != ST_OK |=> $stable(fill_ff))
      else $error("failed command changed the list length");

   a_find_hold : assert property (@(posedge clock) disable iff (reset)
      eval_ff && find_dec |=> fill_ff == $past(fill_ff))
      else $error("find changed the list length");

endmodule
